/* sv/mm4_pkg.sv */
`default_nettype none

package mm4_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int POS_W  = 4;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]         pos_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN
	} mm4_state_t;

	typedef struct packed {
		logic issue;
		logic first;
		logic last;
	} mm4_mac_ctl_t;

	localparam data_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

/* sv/mm4_load_if.sv */
`default_nettype none

interface mm4_load_if;
	logic            valid;
	logic            ready;
	mm4_pkg::data_t  a_element;
	mm4_pkg::data_t  b_element;

	modport source (output valid, output a_element, output b_element, input ready);
	modport sink (input valid, input a_element, input b_element, output ready);
endinterface

`default_nettype wire

/* sv/mm4_result_if.sv */
`default_nettype none

interface mm4_result_if;
	logic            valid;
	logic            ready;
	mm4_pkg::data_t  product_element;
	mm4_pkg::pos_t   element_position;
	logic            last_of_run;

	modport source (
		output valid, output product_element, output element_position,
		output last_of_run, input ready
	);
	modport sink (
		input valid, input product_element, input element_position,
		input last_of_run, output ready
	);
endinterface

`default_nettype wire

/* sv/mm4_ram.sv */
`default_nettype none

module mm4_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* sv/mm4_mac.sv */
`default_nettype none

module mm4_mac #(
	parameter int DIM = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mm4_pkg::mm4_mac_ctl_t ctl,
	input  mm4_pkg::data_t       a_data,
	input  mm4_pkg::data_t       b_data,
	output logic                 done,
	output mm4_pkg::data_t       res
);

	localparam int PROD_W = 2 * mm4_pkg::DATA_W;
	localparam int ACC_W  = PROD_W + $clog2(DIM);
	localparam int TOP_LO = mm4_pkg::FRAC_W + mm4_pkg::DATA_W - 1;

	mm4_pkg::mm4_mac_ctl_t ctl_s1;
	mm4_pkg::mm4_mac_ctl_t ctl_s2;
	logic                  fin_s3;
	logic                  done_q;

	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	mm4_pkg::data_t           res_q;

	logic [ACC_W-1-TOP_LO:0]  acc_hi;
	logic                     fits;
	mm4_pkg::data_t           sat;

	// control pipeline, aligned with the registered memory data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			fin_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			fin_s3 <= ctl_s2.issue & ctl_s2.last;
			if (fin_s3) begin
				done_q <= 1'b1;
			end else if (ctl.issue && ctl.first) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(a_data) * PROD_W'(b_data);
		if (ctl_s2.issue) begin
			acc_q <= ctl_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
		if (fin_s3) begin
			res_q <= sat;
		end
	end

	// shift right by the fraction width, saturate to the data range
	always_comb begin
		acc_hi = acc_q[ACC_W-1:TOP_LO];
		fits   = (&acc_hi) | (~|acc_hi);
		if (fits) begin
			sat = acc_q[TOP_LO:mm4_pkg::FRAC_W];
		end else begin
			sat = acc_q[ACC_W-1] ? mm4_pkg::SAT_MIN : mm4_pkg::SAT_MAX;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

/* sv/matrix_multiply_4x4.sv */
// DIM x DIM signed Q16.16 matrix multiplier. Load DIM*DIM items, each with one
// element of A and the element of B at the same place, in row-major order;
// load is ready only while loading. After the last load the block works out
// A times B one element at a time on a single 32x32 multiply-accumulate unit
// fed from two element memories, each with one write and one read port, and
// emits the elements in row-major order with last_of_run on the final one.
// For each element the unit reads and multiplies DIM pairs and sums the
// products in turn. Each element is the exact sum of DIM products shifted
// right by 16 (toward minus infinity) and saturated to 32 bits. The output
// register lets the next element compute while the previous one waits, and
// loading of the next run may begin while the final element is still waiting
// to be taken.
`default_nettype none

module matrix_multiply_4x4 #(
	parameter int DIM = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	mm4_load_if.sink      load,
	mm4_result_if.source  result
);

	localparam int CELLS = DIM * DIM;
	localparam int AW    = $clog2(CELLS);
	localparam int KW    = $clog2(DIM);

	mm4_pkg::mm4_state_t   state_q;
	mm4_pkg::mm4_state_t   state_d;
	mm4_pkg::mm4_mac_ctl_t ctl;

	logic          load_ready;
	logic          load_fire;
	logic          out_fire;
	logic          capture;
	logic          elem_last;
	logic          mac_done;
	mm4_pkg::data_t mac_res;
	mm4_pkg::data_t a_rd;
	mm4_pkg::data_t b_rd;

	logic [AW-1:0] load_cnt_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] col_q;
	logic [AW-1:0] elem_q;
	logic [AW-1:0] a_base_q;
	logic [AW-1:0] a_addr_q;
	logic [AW-1:0] b_addr_q;

	logic           res_valid_q;
	mm4_pkg::data_t res_data_q;
	mm4_pkg::pos_t  res_pos_q;
	logic           res_last_q;

	assign load_fire = load.valid & load_ready;
	assign out_fire  = res_valid_q & result.ready;
	assign elem_last = (elem_q == AW'(CELLS - 1));

	mm4_ram #(.DEPTH(CELLS), .AW(AW), .DW(mm4_pkg::DATA_W)) u_left (
		.clk   (clk),
		.we    (load_fire),
		.waddr (load_cnt_q),
		.wdata (load.a_element),
		.raddr (a_addr_q),
		.rdata (a_rd)
	);

	mm4_ram #(.DEPTH(CELLS), .AW(AW), .DW(mm4_pkg::DATA_W)) u_right (
		.clk   (clk),
		.we    (load_fire),
		.waddr (load_cnt_q),
		.wdata (load.b_element),
		.raddr (b_addr_q),
		.rdata (b_rd)
	);

	mm4_mac #(.DIM(DIM)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a_data (a_rd),
		.b_data (b_rd),
		.done   (mac_done),
		.res    (mac_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm4_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		load_ready = 1'b0;
		ctl        = '0;
		capture    = 1'b0;
		unique case (state_q)
			mm4_pkg::ST_LOAD: begin
				load_ready = 1'b1;
				if (load.valid && load_cnt_q == AW'(CELLS - 1)) begin
					state_d = mm4_pkg::ST_ISSUE;
				end
			end
			mm4_pkg::ST_ISSUE: begin
				ctl.issue = 1'b1;
				ctl.first = (k_q == '0);
				ctl.last  = (k_q == KW'(DIM - 1));
				if (ctl.last) begin
					state_d = mm4_pkg::ST_DRAIN;
				end
			end
			mm4_pkg::ST_DRAIN: begin
				if (mac_done && (!res_valid_q || result.ready)) begin
					capture = 1'b1;
					state_d = elem_last ? mm4_pkg::ST_LOAD : mm4_pkg::ST_ISSUE;
				end
			end
			default: begin
				state_d = mm4_pkg::ST_LOAD;
			end
		endcase
	end

	// load count, read address walk and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q  <= '0;
			k_q         <= '0;
			col_q       <= '0;
			elem_q      <= '0;
			a_base_q    <= '0;
			a_addr_q    <= '0;
			b_addr_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_fire) begin
				load_cnt_q <= (load_cnt_q == AW'(CELLS - 1)) ? '0 : load_cnt_q + AW'(1);
			end
			if (ctl.issue) begin
				if (ctl.last) begin
					k_q <= '0;
				end else begin
					k_q      <= k_q + KW'(1);
					a_addr_q <= a_addr_q + AW'(1);
					b_addr_q <= b_addr_q + AW'(DIM);
				end
			end
			if (capture) begin
				if (elem_last) begin
					elem_q   <= '0;
					col_q    <= '0;
					a_base_q <= '0;
					a_addr_q <= '0;
					b_addr_q <= '0;
				end else begin
					elem_q <= elem_q + AW'(1);
					if (col_q == KW'(DIM - 1)) begin
						col_q    <= '0;
						a_base_q <= a_base_q + AW'(DIM);
						a_addr_q <= a_base_q + AW'(DIM);
						b_addr_q <= '0;
					end else begin
						col_q    <= col_q + KW'(1);
						a_addr_q <= a_base_q;
						b_addr_q <= AW'(col_q) + AW'(1);
					end
				end
			end
			if (capture) begin
				res_valid_q <= 1'b1;
			end else if (out_fire) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			res_data_q <= mac_res;
			res_pos_q  <= mm4_pkg::POS_W'(elem_q);
			res_last_q <= elem_last;
		end
	end

	assign load.ready              = load_ready;
	assign result.valid            = res_valid_q;
	assign result.product_element  = res_data_q;
	assign result.element_position = res_pos_q;
	assign result.last_of_run      = res_last_q;

endmodule

`default_nettype wire

/* sv/mm4_checker.sv */
`default_nettype none

module mm4_checker #(
	parameter int DIM = 4
) (
	input logic           clk,
	input logic           arst_n,
	input logic           load_ready,
	input logic           result_valid,
	input logic           result_ready,
	input mm4_pkg::data_t product_element,
	input mm4_pkg::pos_t  element_position,
	input logic           last_of_run
);

	localparam int CELLS = DIM * DIM;

	// final element sits at the last row-major position
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_of_run |->
			element_position == mm4_pkg::POS_W'(CELLS - 1))
	else $error("last item not at final position");

	// no loading while a run still has elements to deliver
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_run |-> !load_ready)
	else $error("load ready in the middle of a result run");

	// valid drops once the final element is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && last_of_run |=> !result_valid)
	else $error("item emitted after end of run");

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(product_element) && $stable(element_position))
	else $error("stalled result changed");

endmodule

bind matrix_multiply_4x4 mm4_checker #(.DIM(DIM)) u_mm4_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.load_ready       (load.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.product_element  (result.product_element),
	.element_position (result.element_position),
	.last_of_run      (result.last_of_run)
);

`default_nettype wire
